// ----- rtl/core/mph_pkg.sv -----
// ----------------------------------------------------------------------------
// mph_pkg
// Shared constants, types and window functions of the 3x3 morphology stream.
// ----------------------------------------------------------------------------
package mph_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W   = 8;
	localparam int COORD_W = 10;
	localparam int DIM_W   = 11;
	localparam int WIN_N   = 9;

	localparam int LINE_DEPTH = 2 * MAX_WIDTH;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int COL_AW     = $clog2(MAX_WIDTH);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		MODE_GRAY_ERODE  = 2'd0,
		MODE_GRAY_DILATE = 2'd1,
		MODE_BIN_ERODE   = 2'd2,
		MODE_BIN_DILATE  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [PIX_W-1:0]   out_pixel;
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic               last;
	} result_t;

	// Position and neighborhood flags of one pixel in flight
	typedef struct packed {
		logic [3:0]         emit;
		logic               c_ge1;
		logic               c_ge2;
		logic               r_ge1;
		logic               r_ge2;
		logic               c_eq1;
		logic               r_eq1;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} mph_ctl_t;

	// Window cells (row*3+col) that lie in the image for a center at (rr,cc)
	function automatic logic [WIN_N-1:0] mph_mask(input int rr, input int cc,
			input logic col_lo_ok, input logic row_lo_ok);
		logic [WIN_N-1:0] m;
		m = '0;
		for (int ri = 0; ri < 3; ri++) begin
			for (int ci = 0; ci < 3; ci++) begin
				if (ri >= rr - 1 && ri <= rr + 1 && ci >= cc - 1 && ci <= cc + 1 &&
						(ci != cc - 1 || col_lo_ok) && (ri != rr - 1 || row_lo_ok)) begin
					m[ri*3+ci] = 1'b1;
				end
			end
		end
		return m;
	endfunction

	// Apply the selected operation to the masked window
	function automatic logic [PIX_W-1:0] mph_op(input logic [WIN_N-1:0][PIX_W-1:0] win,
			input logic [WIN_N-1:0] mask, input logic [3:0] ctr, input logic border,
			input mode_t mode);
		logic [PIX_W-1:0] mn;
		logic [PIX_W-1:0] mx;
		logic [PIX_W-1:0] center;
		logic             any_zero;
		logic             any_nz;
		logic [PIX_W-1:0] res;
		mn       = PIX_MAX;
		mx       = '0;
		any_zero = 1'b0;
		any_nz   = 1'b0;
		center   = win[ctr];
		for (int i = 0; i < WIN_N; i++) begin
			if (mask[i]) begin
				if (win[i] < mn) mn = win[i];
				if (win[i] > mx) mx = win[i];
				if (4'(i) != ctr) begin
					if (win[i] == '0) any_zero = 1'b1;
					else any_nz = 1'b1;
				end
			end
		end
		unique case (mode)
			MODE_GRAY_ERODE:  res = mn;
			MODE_GRAY_DILATE: res = mx;
			MODE_BIN_ERODE:   res = (!border && center != '0 && any_zero) ? '0 : center;
			MODE_BIN_DILATE:  res = (!border && center == '0 && any_nz) ? PIX_MAX : center;
			default:          res = center;
		endcase
		return res;
	endfunction

endpackage

// ----- rtl/core/mph_pix_if.sv -----
// ----------------------------------------------------------------------------
// mph_pix_if
// Source pixel channel: valid/ready handshake with one 8-bit pixel.
// ----------------------------------------------------------------------------
interface mph_pix_if;
	logic                      valid;
	logic                      ready;
	logic [mph_pkg::PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

// ----- rtl/core/mph_res_if.sv -----
// ----------------------------------------------------------------------------
// mph_res_if
// Result channel: valid/ready handshake with filtered pixel and coordinates.
// ----------------------------------------------------------------------------
interface mph_res_if;
	logic                        valid;
	logic                        ready;
	logic [mph_pkg::PIX_W-1:0]   out_pixel;
	logic [mph_pkg::COORD_W-1:0] out_x;
	logic [mph_pkg::COORD_W-1:0] out_y;
	logic                        last;

	modport source (output valid, output out_pixel, output out_x, output out_y,
		output last, input ready);
	modport sink   (input valid, input out_pixel, input out_x, input out_y,
		input last, output ready);
endinterface

// ----- rtl/core/mph_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mph_cfg_if
// Register write channel: valid/ready handshake with register index and data.
// ----------------------------------------------------------------------------
interface mph_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mph_pkg::CFG_IDX_W-1:0]  index;
	logic [mph_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/morphology_3x3_stream.sv -----
// ----------------------------------------------------------------------------
// morphology_3x3_stream
// 3x3 gray/binary erosion and dilation over a raster-order 8-bit pixel stream.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+--------------------------------------------
//  pix     | in  | valid/ready  | pixel[7:0]
//  res     | out | valid/ready  | out_pixel[7:0], out_x[9:0], out_y[9:0], last
//  cfg     | in  | valid/ready  | index[1:0] (0 mode, 1 width, 2 height), data
//
//  One pixel transfer per clock when results drain as fast as they appear.
//  Each result passes stage 1, the result buffer and the output register.
//  At a row end or in the last row a pixel yields up to four results; the
//  result buffer drains one per cycle while the output is free, and input
//  ready drops until it holds at most one. The registered line store read sets
//  the first stage. No clearing pass at reset; configuration is always ready.
//
module morphology_3x3_stream (
	input  logic    clk,
	input  logic    arst_n,
	mph_pix_if.sink   pix,
	mph_res_if.source res,
	mph_cfg_if.sink   cfg
);
	import mph_pkg::*;

	// Configuration and position counters
	mode_t              mode_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [DIM_W-1:0]   w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic               c_last;
	logic               r_last;
	logic               pix_acc;
	logic               cfg_acc;
	mph_ctl_t           ctl_in;

	// Line store: two rows, bank chosen by row parity
	logic [PIX_W-1:0]   line_mem [LINE_DEPTH];
	logic [LINE_AW-1:0] addr_a;
	logic [LINE_AW-1:0] addr_b;

	// Stage 1: read data, pixel and position
	logic               valid_s1;
	mph_ctl_t           ctl_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [PIX_W-1:0]   rd_a_s1;
	logic [PIX_W-1:0]   rd_b_s1;
	logic               s1_adv;

	// Stage 2: up to four pending results
	logic [3:0]         mask_s2;
	result_t [3:0]      res_s2;
	result_t [3:0]      res_new;
	logic [3:0]         pop_oh;
	logic [3:0]         mask_after;
	logic               pop;
	logic               s2_free;
	result_t            sel;

	// Output register
	logic               out_valid_q;
	result_t            out_q;
	logic               out_free;

	assign pix_acc   = pix.valid & pix.ready;
	assign cfg_acc   = cfg.valid & cfg.ready;
	assign cfg.ready = 1'b1;

	// Clamp the geometry: zero counts as one, oversize saturates
	always_comb begin
		priority if (width_q == '0) w_eff = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
		else w_eff = width_q;
		priority if (height_q == '0) h_eff = DIM_W'(1);
		else if (height_q > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
		else h_eff = height_q;
	end

	assign c_last = (DIM_W'(col_q) == w_eff - DIM_W'(1));
	assign r_last = (DIM_W'(row_q) == h_eff - DIM_W'(1));

	// Which results this pixel completes, and which window cells are in the image
	always_comb begin
		ctl_in.c_ge1 = (col_q != '0);
		ctl_in.c_ge2 = (col_q > COORD_W'(1));
		ctl_in.r_ge1 = (row_q != '0);
		ctl_in.r_ge2 = (row_q > COORD_W'(1));
		ctl_in.c_eq1 = (col_q == COORD_W'(1));
		ctl_in.r_eq1 = (row_q == COORD_W'(1));
		ctl_in.col   = col_q;
		ctl_in.row   = row_q;
		ctl_in.emit  = {r_last & c_last, r_last & ctl_in.c_ge1,
			ctl_in.r_ge1 & c_last, ctl_in.r_ge1 & ctl_in.c_ge1};
	end

	// Register writes and raster counters; a geometry write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_GRAY_ERODE;
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_acc) begin
			unique case (cfg.index)
				REG_MODE: begin
					mode_q <= mode_t'(cfg.data[1:0]);
				end
				REG_WIDTH: begin
					width_q <= cfg.data;
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_HEIGHT: begin
					height_q <= cfg.data;
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (pix_acc) begin
			if (c_last) begin
				col_q <= '0;
				row_q <= r_last ? '0 : row_q + COORD_W'(1);
			end else begin
				col_q <= col_q + COORD_W'(1);
			end
		end
	end

	// Read rows r-2 and r-1, then overwrite row r-2 with the new pixel
	assign addr_a = {row_q[0], col_q[COL_AW-1:0]};
	assign addr_b = {~row_q[0], col_q[COL_AW-1:0]};

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			rd_a_s1         <= line_mem[addr_a];
			rd_b_s1         <= line_mem[addr_b];
			line_mem[addr_a] <= pix.pixel;
		end
	end

	// Stage 1 holds while the result buffer still has work
	assign s1_adv    = valid_s1 & s2_free;
	assign pix.ready = ~valid_s1 | s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			ctl_s1 <= ctl_in;
			pix_s1 <= pix.pixel;
		end
	end

	// Shift the window and compute every candidate result
	mph_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (s1_adv),
		.column  ({pix_s1, rd_b_s1, rd_a_s1}),
		.ctl     (ctl_s1),
		.mode    (mode_q),
		.results (res_new)
	);

	// Drain pending results lowest first, one per cycle while the output register is free
	assign out_free   = ~out_valid_q | res.ready;
	assign pop        = (mask_s2 != '0) & out_free;
	assign pop_oh     = mask_s2 & (~mask_s2 + 4'd1);
	assign mask_after = pop ? (mask_s2 & ~pop_oh) : mask_s2;
	assign s2_free    = (mask_after == '0);

	always_comb begin
		priority if (mask_s2[0]) sel = res_s2[0];
		else if (mask_s2[1]) sel = res_s2[1];
		else if (mask_s2[2]) sel = res_s2[2];
		else sel = res_s2[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (s1_adv) begin
			mask_s2 <= ctl_s1.emit;
		end else begin
			mask_s2 <= mask_after;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2 <= res_new;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= sel;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.out_pixel = out_q.out_pixel;
	assign res.out_x     = out_q.out_x;
	assign res.out_y     = out_q.out_y;
	assign res.last      = out_q.last;

	// The raster position always lies inside the clamped image
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		DIM_W'(col_q) < w_eff)
		else $error("column counter outside image width");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		DIM_W'(row_q) < h_eff)
		else $error("row counter outside image height");

	// A stalled first stage keeps its pixel and position
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(ctl_s1) && $stable(pix_s1)))
		else $error("stage 1 lost its item while stalled");

	// A new result set is loaded only after the previous one has drained
	a_s2_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |-> (mask_s2 == '0 || (pop && mask_after == '0)))
		else $error("result buffer overwritten with results pending");

endmodule

// ----- rtl/core/mph_window.sv -----
// ----------------------------------------------------------------------------
// mph_window
// 3x3 window shift register and the four candidate results of one pixel.
// ----------------------------------------------------------------------------
module mph_window (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 shift,
	input  logic [2:0][mph_pkg::PIX_W-1:0]       column,
	input  mph_pkg::mph_ctl_t                    ctl,
	input  mph_pkg::mode_t                       mode,
	output mph_pkg::result_t [3:0]               results
);
	import mph_pkg::*;

	// Per row: [0] is window column 0, [1] is window column 1
	logic [2:0][1:0][PIX_W-1:0]     win_q;
	logic [WIN_N-1:0][PIX_W-1:0]    nwin;

	// Window as it stands once the new column has shifted in
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nwin[r*3+0] = win_q[r][0];
			nwin[r*3+1] = win_q[r][1];
			nwin[r*3+2] = column[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r] <= {column[r], win_q[r][1]};
			end
		end
	end

	always_comb begin
		// Center (c-1, r-1)
		results[0].out_pixel = mph_op(nwin, mph_mask(1, 1, ctl.c_ge2, ctl.r_ge2), 4'd4,
			ctl.c_eq1 | ctl.r_eq1, mode);
		results[0].out_x     = ctl.col - COORD_W'(1);
		results[0].out_y     = ctl.row - COORD_W'(1);
		results[0].last      = 1'b0;
		// Right edge of the previous row
		results[1].out_pixel = mph_op(nwin, mph_mask(1, 2, ctl.c_ge1, ctl.r_ge2), 4'd5,
			1'b1, mode);
		results[1].out_x     = ctl.col;
		results[1].out_y     = ctl.row - COORD_W'(1);
		results[1].last      = 1'b0;
		// Bottom row, one column back
		results[2].out_pixel = mph_op(nwin, mph_mask(2, 1, ctl.c_ge2, ctl.r_ge1), 4'd7,
			1'b1, mode);
		results[2].out_x     = ctl.col - COORD_W'(1);
		results[2].out_y     = ctl.row;
		results[2].last      = 1'b0;
		// Bottom right corner: final pixel of the frame
		results[3].out_pixel = mph_op(nwin, mph_mask(2, 2, ctl.c_ge1, ctl.r_ge1), 4'd8,
			1'b1, mode);
		results[3].out_x     = ctl.col;
		results[3].out_y     = ctl.row;
		results[3].last      = 1'b1;
	end

endmodule

// ----- dv/morphology_3x3_stream_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morphology_3x3_stream_tb
// Self-checking bench for the 3x3 morphology stream. Pixels go in through the
// pixel channel while an in-bench window model builds the expected results.
// Each result transfer is checked field by field, in order. Directed frames
// cover every operation and the geometry corner cases. Random frames follow,
// with random idle gaps on both channels and forced back-pressure.
// ----------------------------------------------------------------------------
module morphology_3x3_stream_tb;
	import mph_pkg::*;

	// Unused register slot: a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int  SETTLE_CYCLES = 12;          // pipeline depth plus margin
	localparam int  RANDOM_PIXELS = 130;
	localparam int  EDGE_PIXELS   = 16;
	localparam real LIMIT_NS      = 2000000.0 * 12.0;

	// Pixel content styles for random frames
	localparam int STYLE_UNIFORM = 0;
	localparam int STYLE_HALF    = 1;
	localparam int STYLE_DENSE   = 2;
	localparam int STYLE_SPARSE  = 3;

	logic clk;
	logic arst_n;

	mph_pix_if pix ();
	mph_res_if res ();
	mph_cfg_if cfg ();

	morphology_3x3_stream DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	int      errors;
	bit      src_idle_on;
	bit      sink_idle_on;
	int      sink_hold_req;
	int      rand_pixels;

	// Results still owed by the block, oldest first
	result_t filtered_q [$];
	result_t want;

	// Window model state: two-row line store, 3x3 window, raster position
	logic [PIX_W-1:0] line_mem [LINE_DEPTH];
	logic [PIX_W-1:0] win [WIN_N];
	int               col_pos;
	int               row_pos;
	mode_t            cur_mode;
	logic [DIM_W-1:0] cur_width;
	logic [DIM_W-1:0] cur_height;

	// Zero reads as one, anything above the maximum saturates
	function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int top);
		if (v == '0) return 1;
		if (int'(v) > top) return top;
		return int'(v);
	endfunction

	// Filter the window around column cc, row rr; (ox,oy) is that pixel's image position
	function automatic result_t window_result(input int cc, input int rr, input int ox,
			input int oy, input int w, input int h);
		result_t          r;
		logic [PIX_W-1:0] center;
		logic [PIX_W-1:0] v;
		logic [PIX_W-1:0] lo;
		logic [PIX_W-1:0] hi;
		bit               any_zero;
		bit               any_set;
		int               ci;
		int               ri;
		center   = win[rr*3+cc];
		lo       = PIX_MAX;
		hi       = '0;
		any_zero = 1'b0;
		any_set  = 1'b0;
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				ci = cc + dx;
				ri = rr + dy;
				if (ci < 0 || ci > 2 || ri < 0 || ri > 2) continue;
				// only neighbors that lie inside the image take part
				if (ox + dx < 0 || ox + dx >= w || oy + dy < 0 || oy + dy >= h) continue;
				v = win[ri*3+ci];
				if (v < lo) lo = v;
				if (v > hi) hi = v;
				if (dx != 0 || dy != 0) begin
					if (v == '0) any_zero = 1'b1;
					else any_set = 1'b1;
				end
			end
		end
		if (cur_mode == MODE_GRAY_ERODE) begin
			r.out_pixel = lo;
		end else if (cur_mode == MODE_GRAY_DILATE) begin
			r.out_pixel = hi;
		end else if (ox == 0 || oy == 0 || ox == w - 1 || oy == h - 1) begin
			// binary modes leave the image border untouched
			r.out_pixel = center;
		end else if (cur_mode == MODE_BIN_ERODE) begin
			r.out_pixel = (center != '0 && any_zero) ? '0 : center;
		end else begin
			r.out_pixel = (center == '0 && any_set) ? PIX_MAX : center;
		end
		r.out_x = COORD_W'(ox);
		r.out_y = COORD_W'(oy);
		r.last  = (ox == w - 1 && oy == h - 1);
		return r;
	endfunction

	// Shift one accepted pixel into the window and queue every result it completes
	function automatic void apply_window(input logic [PIX_W-1:0] p);
		int w;
		int h;
		int c;
		int r;
		w = clamp_dim(cur_width, MAX_WIDTH);
		h = clamp_dim(cur_height, MAX_HEIGHT);
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		c = col_pos;
		r = row_pos;
		for (int k = 0; k < 3; k++) begin
			win[k*3+0] = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = line_mem[(r % 2) * MAX_WIDTH + c];
		win[5] = line_mem[((r + 1) % 2) * MAX_WIDTH + c];
		win[8] = p;
		line_mem[(r % 2) * MAX_WIDTH + c] = p;
		if (r >= 1 && c >= 1)     filtered_q.push_back(window_result(1, 1, c - 1, r - 1, w, h));
		if (r >= 1 && c == w - 1) filtered_q.push_back(window_result(2, 1, c, r - 1, w, h));
		if (r == h - 1 && c >= 1) filtered_q.push_back(window_result(1, 2, c - 1, r, w, h));
		if (r == h - 1 && c == w - 1) filtered_q.push_back(window_result(2, 2, c, r, w, h));
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	// Idle length: mostly short, now and then a long stretch
	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel(input int style);
		case (style)
			STYLE_HALF:   return ($urandom_range(0, 1) == 0) ? '0 : PIX_W'($urandom_range(1, 255));
			STYLE_DENSE:  return ($urandom_range(0, 7) == 0) ? '0 : PIX_W'($urandom_range(1, 255));
			STYLE_SPARSE: return ($urandom_range(0, 7) == 0) ? PIX_W'($urandom_range(1, 255)) : '0;
			default:      return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result side: ready with random stalls, plus long hold-offs on request
	// ------------------------------------------------------------------------
	initial begin : sink_side
		int idle_left;
		idle_left = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_req > 0) begin
				idle_left     = sink_hold_req;
				sink_hold_req = 0;
			end
			if (!arst_n) begin
				res.ready <= 1'b0;
			end else if (idle_left > 0) begin
				// hold ready low and count the stall down
				res.ready <= 1'b0;
				idle_left--;
			end else begin
				res.ready <= 1'b1;
				if (sink_idle_on && $urandom_range(0, 4) == 0) idle_left = idle_len();
			end
		end
	end

	// Compare every result transfer with the oldest owed result
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected result pixel=%0d x=%0d y=%0d last=%0d", $time,
					res.out_pixel, res.out_x, res.out_y, res.last);
				errors++;
			end else begin
				want = filtered_q.pop_front();
				if (res.out_pixel !== want.out_pixel) begin
					$display("%0t: out_pixel at (%0d,%0d) expected %0d actual %0d", $time,
						want.out_x, want.out_y, want.out_pixel, res.out_pixel);
					errors++;
				end
				if (res.out_x !== want.out_x) begin
					$display("%0t: out_x expected %0d actual %0d", $time, want.out_x, res.out_x);
					errors++;
				end
				if (res.out_y !== want.out_y) begin
					$display("%0t: out_y expected %0d actual %0d", $time, want.out_y, res.out_y);
					errors++;
				end
				if (res.last !== want.last) begin
					$display("%0t: last at (%0d,%0d) expected %0d actual %0d", $time,
						want.out_x, want.out_y, want.last, res.last);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Pixel side
	// ------------------------------------------------------------------------

	// Offer one pixel and return after its transfer; valid stays high so that
	// a back-to-back pixel never sees valid drop and rise in one step
	task automatic send_pixel(input logic [PIX_W-1:0] p);
		int gap;
		gap = (src_idle_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel <= p;
		do @(posedge clk); while (!pix.ready);
		apply_window(p);
	endtask

	// Drop valid once a run of pixels is done
	task automatic release_pixels();
		pix.valid <= 1'b0;
	endtask

	task automatic send_list(input logic [PIX_W-1:0] vals [9], input int n);
		for (int i = 0; i < n; i++) send_pixel(vals[i]);
		release_pixels();
	endtask

	task automatic send_run(input int n, input int style);
		for (int i = 0; i < n; i++) send_pixel(rand_pixel(style));
		release_pixels();
	endtask

	task automatic wait_drained();
		while (filtered_q.size() != 0) @(posedge clk);
	endtask

	// Registers change only with the block idle: drain, then let any pixel
	// that completes no window leave the pipeline too
	task automatic wait_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drop valid after the transfer and hold it low for one cycle before returning
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_MODE: cur_mode = mode_t'(data[1:0]);
			REG_WIDTH: begin
				cur_width = data;
				col_pos   = 0;
				row_pos   = 0;
			end
			REG_HEIGHT: begin
				cur_height = data;
				col_pos    = 0;
				row_pos    = 0;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_frame(input mode_t m, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		write_reg(REG_MODE, CFG_DATA_W'(m));
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset geometry is 1024x1024: the first row completes no window
	task automatic test_reset_geometry();
		send_pixel(8'd0);
		send_pixel(8'd255);
		release_pixels();
		wait_idle();
	endtask

	task automatic test_gray_ops();
		logic [PIX_W-1:0] img [9];
		// high data bits of the mode register are ignored
		write_reg(REG_MODE, {9'h1FF, MODE_GRAY_ERODE});
		write_reg(REG_WIDTH, 11'd2);
		write_reg(REG_HEIGHT, 11'd2);
		img = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
		send_list(img, 4);
		wait_idle();
		// single column, two rows
		set_frame(MODE_GRAY_DILATE, 11'd1, 11'd2);
		img = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
		send_list(img, 2);
		wait_idle();
	endtask

	task automatic test_binary_ops();
		logic [PIX_W-1:0] img [9];
		// center has a zero neighbor and is cleared; border pixels pass through
		set_frame(MODE_BIN_ERODE, 11'd3, 11'd3);
		img = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd7, 8'd255, 8'd255, 8'd255, 8'd255};
		send_list(img, 9);
		wait_idle();
		// zero center with one set neighbor becomes 255
		write_reg(REG_MODE, CFG_DATA_W'(MODE_BIN_DILATE));
		img = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1};
		send_list(img, 9);
		wait_idle();
	endtask

	// Zero width reads as one: every pixel is a whole 1x1 image
	task automatic test_unit_image();
		logic [PIX_W-1:0] img [9];
		write_reg(REG_SPARE, 11'h7FF);
		set_frame(MODE_GRAY_ERODE, 11'd0, 11'd1);
		img = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
		send_list(img, 2);
		wait_idle();
	endtask

	// Oversize geometry saturates; run the start of a wide row and of a tall column
	task automatic test_max_geometry();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		set_frame(MODE_BIN_DILATE, 11'd2047, 11'd0);
		send_run(EDGE_PIXELS, STYLE_SPARSE);
		wait_idle();
		set_frame(MODE_GRAY_DILATE, 11'd0, 11'd2047);
		send_run(EDGE_PIXELS, STYLE_UNIFORM);
		wait_idle();
	endtask

	task automatic test_backpressure();
		// receiver holds off while pixels keep coming: the block must stall
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		set_frame(MODE_GRAY_DILATE, 11'd5, 11'd8);
		@(posedge clk);
		sink_hold_req = 200;
		send_run(40, STYLE_UNIFORM);
		wait_idle();
		// sender pauses mid-frame until everything owed has come out
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		set_frame(MODE_BIN_ERODE, 11'd6, 11'd4);
		send_run(12, STYLE_DENSE);
		wait_drained();
		send_run(12, STYLE_DENSE);
		wait_idle();
	endtask

	task automatic test_random_frames();
		int    w;
		int    h;
		int    n;
		mode_t m;
		while (rand_pixels < RANDOM_PIXELS) begin
			// alternate stretches with and without idling
			src_idle_on  = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			m = mode_t'($urandom_range(0, 3));
			write_reg(REG_MODE, CFG_DATA_W'(m));
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 7) == 0) begin
					w = $urandom_range(9, 40);
					h = $urandom_range(1, 3);
				end else begin
					w = $urandom_range(1, 8);
					h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
				end
				write_reg(REG_WIDTH, DIM_W'(w));
				write_reg(REG_HEIGHT, DIM_W'(h));
			end
			w = clamp_dim(cur_width, MAX_WIDTH);
			h = clamp_dim(cur_height, MAX_HEIGHT);
			// mostly whole frames, back to back; sometimes cut one short
			if ($urandom_range(0, 4) != 0) n = w * h * $urandom_range(1, 2);
			else n = $urandom_range(1, w * h);
			send_run(n, $urandom_range(STYLE_UNIFORM, STYLE_SPARSE));
			rand_pixels += n;
			wait_idle();
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		errors        = 0;
		rand_pixels   = 0;
		sink_hold_req = 0;
		src_idle_on   = 1'b1;
		sink_idle_on  = 1'b1;
		line_mem      = '{default: '0};
		win           = '{default: '0};
		col_pos       = 0;
		row_pos       = 0;
		cur_mode      = MODE_GRAY_ERODE;
		cur_width     = DIM_W'(MAX_WIDTH);
		cur_height    = DIM_W'(MAX_HEIGHT);
		arst_n    <= 1'b0;
		pix.valid <= 1'b0;
		pix.pixel <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_MODE;
		cfg.data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_gray_ops();
		test_binary_ops();
		test_unit_image();
		test_max_geometry();
		test_backpressure();
		test_random_frames();

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("morphology_3x3_stream_tb passed");
		end else begin
			$display("morphology_3x3_stream_tb failed");
		end
		$finish;
	end

	// Watchdog: a stuck handshake or a missing result ends here
	initial begin
		#(LIMIT_NS);
		$display("morphology_3x3_stream_tb failed");
		$finish;
	end

endmodule
